@@ src/handle_queue_with_jump_ahead_macros.svh @@
// Assertion macros shared by the handle queue RTL.
`ifndef HANDLE_QUEUE_WITH_JUMP_AHEAD_MACROS_SVH
`define HANDLE_QUEUE_WITH_JUMP_AHEAD_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define HQJA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked from the cycle after the antecedent.
`define HQJA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/hqja_pkg.sv @@
// Package with types and constants of the handle queue.
`default_nettype none

package hqja_pkg;

    localparam int CAPACITY   = 64;
    localparam int DATA_WIDTH = 32;
    localparam int VALUE_W    = 32;
    localparam int HANDLE_W   = $clog2(CAPACITY);
    localparam int COUNT_W    = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        OP_PUSH  = 2'd0,
        OP_POP   = 2'd1,
        OP_QUERY = 2'd2,
        OP_JUMP  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_STALE = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_LOOK = 2'd1,
        S_EXEC = 2'd2,
        S_RESP = 2'd3
    } t_state;

    typedef struct packed {
        logic capture;
        logic look;
        logic exec;
    } t_cmd;

endpackage

`default_nettype wire

@@ src/handle_queue_with_jump_ahead.sv @@
// Top level of the handle queue with jump-ahead.
`default_nettype none

`include "handle_queue_with_jump_ahead_macros.svh"

// An operation is taken at a rising edge where start is high and busy is low.
// Its result appears on the o_ ports for one cycle after the LOOK and EXEC states,
// marked by o_done; there is no way to hold it off, so sample it then. A new
// word can be taken in the same cycle as o_done, but not before, so operations do
// not overlap. The LOOK state does the parallel compare of all order entries with
// the handle, the free-slot search and the value RAM read of the front slot,
// EXEC the status decision and the one-step shift of the order registers, and
// RESP presents the result. While o_done is high, o_entry_count shows the count
// after the operation. No clearing pass is needed after reset.
module handle_queue_with_jump_ahead #(
    parameter int DATA_WIDTH = hqja_pkg::DATA_WIDTH
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire logic [1:0]                      i_op,
    input  wire logic [hqja_pkg::VALUE_W-1:0]    i_push_value,
    input  wire logic [hqja_pkg::HANDLE_W-1:0]   i_entry_handle,
    input  wire logic [hqja_pkg::HANDLE_W-1:0]   i_jump_distance,
    output logic                                 o_done,
    output logic [hqja_pkg::VALUE_W-1:0]         o_pop_value,
    output logic [hqja_pkg::HANDLE_W-1:0]        o_new_handle,
    output logic [hqja_pkg::HANDLE_W-1:0]        o_entry_position,
    output logic [hqja_pkg::COUNT_W-1:0]         o_entry_count,
    output logic [1:0]                           o_status
);

    hqja_pkg::t_cmd w_cmd;

    hqja_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .o_done  (o_done),
        .o_cmd   (w_cmd)
    );

    hqja_dpath #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .i_op             (i_op),
        .i_push_value     (i_push_value),
        .i_entry_handle   (i_entry_handle),
        .i_jump_distance  (i_jump_distance),
        .o_pop_value      (o_pop_value),
        .o_new_handle     (o_new_handle),
        .o_entry_position (o_entry_position),
        .o_entry_count    (o_entry_count),
        .o_status         (o_status)
    );

    `HQJA_ASSERT_NOW(a_latency, i_clk, i_rst_n, start && !busy, ##3 o_done, "result not three cycles after accept")
    `HQJA_ASSERT_NEXT(a_done_single, i_clk, i_rst_n, o_done, !o_done, "result strobe longer than one cycle")
    `HQJA_ASSERT_NOW(a_count_cap, i_clk, i_rst_n, o_done, o_entry_count <= hqja_pkg::COUNT_W'(hqja_pkg::CAPACITY), "entry count above capacity")
    `HQJA_ASSERT_NOW(a_full_count, i_clk, i_rst_n, o_done && (o_status == hqja_pkg::ST_FULL), o_entry_count == hqja_pkg::COUNT_W'(hqja_pkg::CAPACITY), "full status with room left")

endmodule

`default_nettype wire

@@ src/hqja_ctrl.sv @@
// Controller state machine of the handle queue.
`default_nettype none

module hqja_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    output logic               o_busy,
    output logic               o_done,
    output hqja_pkg::t_cmd     o_cmd
);

    hqja_pkg::t_state r_state;
    hqja_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hqja_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            hqja_pkg::S_IDLE: n_state = i_start ? hqja_pkg::S_LOOK : hqja_pkg::S_IDLE;
            hqja_pkg::S_LOOK: n_state = hqja_pkg::S_EXEC;
            hqja_pkg::S_EXEC: n_state = hqja_pkg::S_RESP;
            hqja_pkg::S_RESP: n_state = i_start ? hqja_pkg::S_LOOK : hqja_pkg::S_IDLE;
            default:          n_state = hqja_pkg::S_IDLE;
        endcase
    end

    // A new word may be taken in the cycle that shows the previous result.
    always_comb begin
        o_busy        = 1'b0;
        o_done        = 1'b0;
        o_cmd.capture = 1'b0;
        o_cmd.look    = 1'b0;
        o_cmd.exec    = 1'b0;
        case (r_state)
            hqja_pkg::S_IDLE: o_cmd.capture = i_start;
            hqja_pkg::S_LOOK: begin
                o_busy     = 1'b1;
                o_cmd.look = 1'b1;
            end
            hqja_pkg::S_EXEC: begin
                o_busy     = 1'b1;
                o_cmd.exec = 1'b1;
            end
            hqja_pkg::S_RESP: begin
                o_done        = 1'b1;
                o_cmd.capture = i_start;
            end
            default: o_busy = 1'b0;
        endcase
    end

endmodule

`default_nettype wire

@@ src/hqja_dpath.sv @@
// Datapath of the handle queue: order registers, slot flags, value RAM, results.
`default_nettype none

module hqja_dpath #(
    parameter int DATA_WIDTH = hqja_pkg::DATA_WIDTH
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire hqja_pkg::t_cmd                  i_cmd,
    input  wire logic [1:0]                      i_op,
    input  wire logic [hqja_pkg::VALUE_W-1:0]    i_push_value,
    input  wire logic [hqja_pkg::HANDLE_W-1:0]   i_entry_handle,
    input  wire logic [hqja_pkg::HANDLE_W-1:0]   i_jump_distance,
    output logic [hqja_pkg::VALUE_W-1:0]         o_pop_value,
    output logic [hqja_pkg::HANDLE_W-1:0]        o_new_handle,
    output logic [hqja_pkg::HANDLE_W-1:0]        o_entry_position,
    output logic [hqja_pkg::COUNT_W-1:0]         o_entry_count,
    output logic [1:0]                           o_status
);

    localparam int CAP = hqja_pkg::CAPACITY;
    localparam int HW  = hqja_pkg::HANDLE_W;
    localparam int CW  = hqja_pkg::COUNT_W;

    // Captured word.
    hqja_pkg::t_op              r_op;
    logic [hqja_pkg::VALUE_W-1:0] r_value;
    logic [HW-1:0]              r_handle;
    logic [HW-1:0]              r_dist;

    // Queue state.
    logic [CW-1:0]              r_count;
    logic [CW-1:0]              n_count;
    logic [CAP-1:0]             r_used;
    logic [CAP-1:0]             n_used;
    logic [HW-1:0]              r_order [CAP];
    logic [HW-1:0]              n_order [CAP];
    logic [DATA_WIDTH-1:0]      r_mem   [CAP];

    // Look-up results.
    logic [CAP-1:0]             r_match;
    logic [CAP-1:0]             r_free_oh;
    logic                       r_handle_used;
    logic [DATA_WIDTH-1:0]      r_rd_data;

    // Result registers.
    logic [hqja_pkg::VALUE_W-1:0] r_pop_value;
    logic [HW-1:0]              r_new_handle;
    logic [HW-1:0]              r_position;
    hqja_pkg::t_status          r_status;

    logic [HW-1:0]              w_match_idx;
    logic [HW-1:0]              w_free_h;
    logic                       w_found;
    logic [HW-1:0]              w_head;
    logic [HW-1:0]              w_to;
    logic                       w_push_ok;
    logic                       w_pop_ok;
    logic                       w_jump_ok;
    logic                       w_query_ok;
    logic [HW-1:0]              w_prev [CAP];
    logic [HW-1:0]              w_next [CAP];

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op     <= hqja_pkg::t_op'(i_op);
            r_value  <= i_push_value;
            r_handle <= i_entry_handle;
            r_dist   <= i_jump_distance;
        end
    end

    // Parallel compare of every order entry with the handle; free-slot search.
    always_ff @(posedge i_clk) begin
        if (i_cmd.look) begin
            for (int i = 0; i < CAP; i++) begin
                r_match[i] <= (r_order[i] == r_handle) && (CW'(i) < r_count);
            end
            r_free_oh     <= ~r_used & (r_used + CAP'(1));
            r_handle_used <= r_used[r_handle];
        end
    end

    // Value RAM: one read port for the front slot, one write port for pushes.
    always_ff @(posedge i_clk) begin
        if (i_cmd.look) begin
            r_rd_data <= r_mem[r_order[0]];
        end
        if (i_cmd.exec && w_push_ok) begin
            r_mem[w_free_h] <= DATA_WIDTH'(r_value);
        end
    end

    always_comb begin
        w_match_idx = '0;
        w_free_h    = '0;
        for (int i = 0; i < CAP; i++) begin
            if (r_match[i]) begin
                w_match_idx = w_match_idx | HW'(i);
            end
            if (r_free_oh[i]) begin
                w_free_h = w_free_h | HW'(i);
            end
        end
    end

    assign w_found    = |r_match;
    assign w_head     = r_order[0];
    assign w_to       = (w_match_idx > r_dist) ? (w_match_idx - r_dist) : '0;
    assign w_push_ok  = (r_op == hqja_pkg::OP_PUSH)  && (r_count != CW'(CAP));
    assign w_pop_ok   = (r_op == hqja_pkg::OP_POP)   && (r_count != '0);
    assign w_query_ok = (r_op == hqja_pkg::OP_QUERY) && r_handle_used && w_found;
    assign w_jump_ok  = (r_op == hqja_pkg::OP_JUMP)  && r_handle_used && w_found;

    // Each order entry shifts only from its neighbors, so shifts are one step wide.
    for (genvar g = 0; g < CAP; g++) begin : g_entry
        if (g == 0) begin : g_first
            assign w_prev[g] = r_order[g];
        end else begin : g_mid
            assign w_prev[g] = r_order[g-1];
        end
        if (g == CAP - 1) begin : g_last
            assign w_next[g] = r_order[g];
        end else begin : g_body
            assign w_next[g] = r_order[g+1];
        end

        always_comb begin
            n_order[g] = r_order[g];
            if (w_push_ok && (CW'(g) == r_count)) begin
                n_order[g] = w_free_h;
            end else if (w_pop_ok) begin
                n_order[g] = w_next[g];
            end else if (w_jump_ok) begin
                if (HW'(g) == w_to) begin
                    n_order[g] = r_handle;
                end else if ((HW'(g) > w_to) && (HW'(g) <= w_match_idx)) begin
                    n_order[g] = w_prev[g];
                end
            end
        end
    end

    always_comb begin
        n_count = r_count;
        n_used  = r_used;
        if (w_push_ok) begin
            n_count = r_count + CW'(1);
            n_used  = r_used | r_free_oh;
        end else if (w_pop_ok) begin
            n_count = r_count - CW'(1);
            n_used  = r_used & ~(CAP'(1) << w_head);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_used  <= '0;
        end else if (i_cmd.exec) begin
            r_count <= n_count;
            r_used  <= n_used;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            for (int i = 0; i < CAP; i++) begin
                r_order[i] <= n_order[i];
            end
            r_pop_value  <= w_pop_ok ? hqja_pkg::VALUE_W'(r_rd_data) : '0;
            r_new_handle <= w_push_ok ? w_free_h : '0;
            r_position   <= '0;
            r_status     <= hqja_pkg::ST_OK;
            case (r_op)
                hqja_pkg::OP_PUSH: begin
                    if (w_push_ok) begin
                        r_position <= r_count[HW-1:0];
                    end else begin
                        r_status <= hqja_pkg::ST_FULL;
                    end
                end
                hqja_pkg::OP_POP: begin
                    if (!w_pop_ok) begin
                        r_status <= hqja_pkg::ST_EMPTY;
                    end
                end
                hqja_pkg::OP_QUERY: begin
                    if (w_query_ok) begin
                        r_position <= w_match_idx;
                    end else begin
                        r_status <= hqja_pkg::ST_STALE;
                    end
                end
                hqja_pkg::OP_JUMP: begin
                    if (w_jump_ok) begin
                        r_position <= w_to;
                    end else begin
                        r_status <= hqja_pkg::ST_STALE;
                    end
                end
                default: r_status <= hqja_pkg::ST_OK;
            endcase
        end
    end

    assign o_pop_value      = r_pop_value;
    assign o_new_handle     = r_new_handle;
    assign o_entry_position = r_position;
    assign o_entry_count    = r_count;
    assign o_status         = r_status;

endmodule

`default_nettype wire
